// File: src/rcm_pkg.sv
package rcm_pkg;

    // Input beat: one received route
    typedef struct packed {
        logic [7:0]  route_load;
        logic [7:0]  route_reliability;
        logic [39:0] route_delay;
        logic [39:0] route_bandwidth;
    } rcm_in_t;

    // Output beat: reported and feasible distance
    typedef struct packed {
        logic [57:0] reported_distance;
        logic [58:0] feasible_distance;
    } rcm_out_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  k_bandwidth;
        logic [7:0]  k_load;
        logic [7:0]  k_delay;
        logic [7:0]  k_reliability;
        logic [7:0]  k_mtu;
        logic [57:0] local_metric;
    } rcm_cfg_t;

    // Register indexes (byte address is 8 times the index)
    typedef enum logic [2:0] {
        REG_K_BANDWIDTH   = 3'd0,
        REG_K_LOAD        = 3'd1,
        REG_K_DELAY       = 3'd2,
        REG_K_RELIABILITY = 3'd3,
        REG_K_MTU         = 3'd4,
        REG_LOCAL_METRIC  = 3'd5
    } rcm_reg_t;

    // Scaled bandwidth numerator
    localparam logic [39:0] BW_NUM = 40'd655360000000;
    // delay * 65536 / 1000000 == (delay * DLY_RCP) >> DLY_SHIFT, exact for delay below 2^40
    localparam logic [50:0] DLY_RCP   = 51'd1180591620717412;
    localparam int          DLY_SHIFT = 54;

    // Stage counts of the three long-division sections
    localparam int BW_STEPS  = 40;
    localparam int LD_STEPS  = 48;
    localparam int RL_STEPS  = 57;
    // Total pipeline depth in register stages
    localparam int LAT = BW_STEPS + LD_STEPS + RL_STEPS + 5;

endpackage

// File: src/rcm_pipe.sv
module rcm_pipe
    import rcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  rcm_cfg_t cfg,
    input  logic     in_valid,
    input  rcm_in_t  in_data,
    output logic     out_valid,
    output rcm_out_t out_data
);

    // Valid bits travel alongside the data
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Section 1: scaled bandwidth one quotient bit a stage, scaled delay
    // by reciprocal multiplication over the first three stages
    // ------------------------------------------------------------------
    logic [39:0] s1_bw_reg   [0:BW_STEPS];
    logic [39:0] s1_rb_reg   [0:BW_STEPS];
    logic [39:0] s1_qb_reg   [0:BW_STEPS];
    logic [39:0] s1_qd_reg   [2:BW_STEPS];
    logic [7:0]  s1_load_reg [0:BW_STEPS];
    logic [7:0]  s1_rel_reg  [0:BW_STEPS];

    logic [44:0] dly_hh_reg;
    logic [45:0] dly_hl_reg;
    logic [44:0] dly_lh_reg;
    logic [45:0] dly_ll_reg;
    logic [44:0] dly_hi_reg;
    logic [71:0] dly_lo_reg;
    logic [90:0] dly_prod;

    // Load the first stage from the input beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bw_reg[0]   <= in_data.route_bandwidth;
            s1_rb_reg[0]   <= '0;
            s1_qb_reg[0]   <= '0;
            s1_load_reg[0] <= in_data.route_load;
            s1_rel_reg[0]  <= in_data.route_reliability;
        end
    end

    always_comb
    begin
        dly_prod = {dly_hi_reg, 46'b0} + {19'b0, dly_lo_reg};
    end

    // Form the partial products, fold the low ones, then add and keep the quotient
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_hh_reg   <= {25'b0, in_data.route_delay[39:20]} * {20'b0, DLY_RCP[50:26]};
            dly_hl_reg   <= {26'b0, in_data.route_delay[39:20]} * {20'b0, DLY_RCP[25:0]};
            dly_lh_reg   <= {25'b0, in_data.route_delay[19:0]} * {20'b0, DLY_RCP[50:26]};
            dly_ll_reg   <= {26'b0, in_data.route_delay[19:0]} * {20'b0, DLY_RCP[25:0]};
            dly_hi_reg   <= dly_hh_reg;
            dly_lo_reg   <= {6'b0, dly_hl_reg, 20'b0} + {1'b0, dly_lh_reg, 26'b0}
                          + {26'b0, dly_ll_reg};
            s1_qd_reg[2] <= {3'b0, dly_prod[DLY_SHIFT+36:DLY_SHIFT]};
        end
    end

    for (genvar j = 0; j < BW_STEPS; j++)
    begin : g_s1
        logic [40:0] sh_b;
        logic        ge_b;
        logic [40:0] df_b;

        always_comb
        begin
            sh_b = {s1_rb_reg[j], BW_NUM[BW_STEPS-1-j]};
            ge_b = (sh_b >= {1'b0, s1_bw_reg[j]});
            df_b = sh_b - {1'b0, s1_bw_reg[j]};
        end

        // Advance one restoring step on the bandwidth quotient
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_rb_reg[j+1]   <= ge_b ? df_b[39:0] : sh_b[39:0];
                s1_qb_reg[j+1]   <= {s1_qb_reg[j][38:0], ge_b};
                s1_bw_reg[j+1]   <= s1_bw_reg[j];
                s1_load_reg[j+1] <= s1_load_reg[j];
                s1_rel_reg[j+1]  <= s1_rel_reg[j];
            end
        end

        // Carry the scaled delay alongside
        if (j >= 2)
        begin : g_qd
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s1_qd_reg[j+1] <= s1_qd_reg[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Weighting: scale the terms and form the load divisor
    // ------------------------------------------------------------------
    logic [39:0] sbw;
    logic [47:0] p1_mul;
    logic [47:0] p3_mul;
    logic [47:0] n2_mul;

    always_comb
    begin
        sbw    = (s1_bw_reg[BW_STEPS] == '0) ? '0 : s1_qb_reg[BW_STEPS];
        p1_mul = {8'b0, sbw} * {40'b0, cfg.k_bandwidth};
        p3_mul = {8'b0, s1_qd_reg[BW_STEPS]} * {40'b0, cfg.k_delay};
        n2_mul = {8'b0, sbw} * {40'b0, cfg.k_load};
    end

    // ------------------------------------------------------------------
    // Section 3: load term, dividend k2*sbw over 256 - load
    // ------------------------------------------------------------------
    logic [47:0] s3_n_reg   [0:LD_STEPS];
    logic [8:0]  s3_d_reg   [0:LD_STEPS];
    logic [8:0]  s3_r_reg   [0:LD_STEPS];
    logic [47:0] s3_q_reg   [0:LD_STEPS];
    logic [47:0] s3_p1_reg  [0:LD_STEPS];
    logic [47:0] s3_p3_reg  [0:LD_STEPS];
    logic [7:0]  s3_rel_reg [0:LD_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_n_reg[0]   <= n2_mul;
            s3_d_reg[0]   <= 9'd256 - {1'b0, s1_load_reg[BW_STEPS]};
            s3_r_reg[0]   <= '0;
            s3_q_reg[0]   <= '0;
            s3_p1_reg[0]  <= p1_mul;
            s3_p3_reg[0]  <= p3_mul;
            s3_rel_reg[0] <= s1_rel_reg[BW_STEPS];
        end
    end

    for (genvar j = 0; j < LD_STEPS; j++)
    begin : g_s3
        logic [9:0] sh;
        logic       ge;
        logic [9:0] df;

        always_comb
        begin
            sh = {s3_r_reg[j], s3_n_reg[j][LD_STEPS-1-j]};
            ge = (sh >= {1'b0, s3_d_reg[j]});
            df = sh - {1'b0, s3_d_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s3_r_reg[j+1]   <= ge ? df[8:0] : sh[8:0];
                s3_q_reg[j+1]   <= {s3_q_reg[j][46:0], ge};
                s3_n_reg[j+1]   <= s3_n_reg[j];
                s3_d_reg[j+1]   <= s3_d_reg[j];
                s3_p1_reg[j+1]  <= s3_p1_reg[j];
                s3_p3_reg[j+1]  <= s3_p3_reg[j];
                s3_rel_reg[j+1] <= s3_rel_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum the terms and form the reliability divisor
    // ------------------------------------------------------------------
    logic [48:0] sum_reg;
    logic [8:0]  den_reg;
    logic        scale_reg;
    logic [8:0]  den;

    always_comb
    begin
        den = {1'b0, s3_rel_reg[LD_STEPS]} + {1'b0, cfg.k_reliability};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg   <= {1'b0, s3_p1_reg[LD_STEPS]} + {1'b0, s3_q_reg[LD_STEPS]}
                       + {1'b0, s3_p3_reg[LD_STEPS]};
            den_reg   <= den;
            scale_reg <= (cfg.k_mtu != '0) && (den != '0);
        end
    end

    // ------------------------------------------------------------------
    // Section 4: reliability scaling, sum*k5 over rel + k4 when k5 and that divisor are
    // nonzero, else the sum passes through divided by one
    logic [56:0] s4_n_reg [0:RL_STEPS];
    logic [8:0]  s4_d_reg [0:RL_STEPS];
    logic [8:0]  s4_r_reg [0:RL_STEPS];
    logic [56:0] s4_q_reg [0:RL_STEPS];
    logic [56:0] n4_mul;

    always_comb
    begin
        n4_mul = {8'b0, sum_reg} * {49'b0, cfg.k_mtu};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_n_reg[0] <= scale_reg ? n4_mul : {8'b0, sum_reg};
            s4_d_reg[0] <= scale_reg ? den_reg : 9'd1;
            s4_r_reg[0] <= '0;
            s4_q_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < RL_STEPS; j++)
    begin : g_s4
        logic [9:0] sh;
        logic       ge;
        logic [9:0] df;

        always_comb
        begin
            sh = {s4_r_reg[j], s4_n_reg[j][RL_STEPS-1-j]};
            ge = (sh >= {1'b0, s4_d_reg[j]});
            df = sh - {1'b0, s4_d_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s4_r_reg[j+1] <= ge ? df[8:0] : sh[8:0];
                s4_q_reg[j+1] <= {s4_q_reg[j][55:0], ge};
                s4_n_reg[j+1] <= s4_n_reg[j];
                s4_d_reg[j+1] <= s4_d_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the local interface metric
    // ------------------------------------------------------------------
    rcm_out_t out_reg;
    logic [57:0] rd;

    always_comb
    begin
        rd = {1'b0, s4_q_reg[RL_STEPS]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.reported_distance <= rd;
            out_reg.feasible_distance <= {1'b0, rd} + {1'b0, cfg.local_metric};
        end
    end

    assign out_data = out_reg;

endmodule

// File: src/route_composite_metric.sv
// Throughput: one route per cycle while the output is not stalled; the three long
// divisions each resolve one quotient bit per pipeline stage, so the whole chain is
// 150 register stages.
// A stalled output beat holds the whole pipeline until it is taken.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads the
// weights with k1 = k3 = 1 and all other registers zero.
module route_composite_metric
    import rcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        route_valid,
    output logic        route_stall,
    input  rcm_in_t     route,
    output logic        metric_valid,
    input  logic        metric_stall,
    output rcm_out_t    metric
);

    rcm_cfg_t cfg_reg;
    rcm_reg_t reg_sel;
    logic     adv;

    assign pready  = 1'b1;
    assign reg_sel = rcm_reg_t'(paddr[5:3]);

    // Write the register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k_bandwidth   <= 8'd1;
            cfg_reg.k_load        <= 8'd0;
            cfg_reg.k_delay       <= 8'd1;
            cfg_reg.k_reliability <= 8'd0;
            cfg_reg.k_mtu         <= 8'd0;
            cfg_reg.local_metric  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_K_BANDWIDTH:   cfg_reg.k_bandwidth   <= pwdata[7:0];
                REG_K_LOAD:        cfg_reg.k_load        <= pwdata[7:0];
                REG_K_DELAY:       cfg_reg.k_delay       <= pwdata[7:0];
                REG_K_RELIABILITY: cfg_reg.k_reliability <= pwdata[7:0];
                REG_K_MTU:         cfg_reg.k_mtu         <= pwdata[7:0];
                REG_LOCAL_METRIC:  cfg_reg.local_metric  <= pwdata[57:0];
                default:           ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_K_BANDWIDTH:   prdata = {56'b0, cfg_reg.k_bandwidth};
            REG_K_LOAD:        prdata = {56'b0, cfg_reg.k_load};
            REG_K_DELAY:       prdata = {56'b0, cfg_reg.k_delay};
            REG_K_RELIABILITY: prdata = {56'b0, cfg_reg.k_reliability};
            REG_K_MTU:         prdata = {56'b0, cfg_reg.k_mtu};
            REG_LOCAL_METRIC:  prdata = {6'b0, cfg_reg.local_metric};
            default:           prdata = '0;
        endcase
    end

    // Advance unless the output beat is held
    assign adv         = !(metric_valid && metric_stall);
    assign route_stall = !adv;

    rcm_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (route_valid),
        .in_data   (route),
        .out_valid (metric_valid),
        .out_data  (metric)
    );

endmodule
